>>> sv/vmm_pkg.sv
package vmm_pkg;

    // field widths of the request and result items
    localparam int COORD_W   = 32;
    localparam int PITCH_W   = 24;
    localparam int ELEM_W    = 9;
    localparam int VOX_IDX_W = 18;
    localparam int OCC_W     = 19;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // default geometry
    localparam int DEF_SIZE_X       = 64;
    localparam int DEF_SIZE_Y       = 64;
    localparam int DEF_SIZE_Z       = 64;
    localparam int DEF_NUM_ELEMENTS = 9;

    // register reset values
    localparam logic signed [COORD_W-1:0] MIN_RESET   = '0;
    localparam logic [PITCH_W-1:0]        PITCH_RESET = PITCH_W'(65536);

    typedef enum logic [0:0] {
        OP_FILL  = 1'b0,
        OP_QUERY = 1'b1
    } vmm_op_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MIN_X   = 3'd0,
        CFG_MIN_Y   = 3'd1,
        CFG_MIN_Z   = 3'd2,
        CFG_PITCH_X = 3'd3,
        CFG_PITCH_Y = 3'd4,
        CFG_PITCH_Z = 3'd5
    } vmm_cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_DIFF,
        ST_MUL,
        ST_CELL,
        ST_ADDR,
        ST_READ,
        ST_RESULT_WAIT,
        ST_DONE
    } vmm_state_t;

    typedef struct packed {
        logic                      opcode;
        logic [ELEM_W-1:0]         element_mask;
        logic                      calculated;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } vmm_in_t;

    typedef struct packed {
        logic [VOX_IDX_W-1:0] voxel_index;
        logic                 inside_res;
        logic                 has_material;
        logic                 overflow;
        logic [ELEM_W-1:0]    element_union;
        logic [OCC_W-1:0]     occupied_count;
    } vmm_out_t;

endpackage

>>> sv/vmm_ram.sv
module vmm_ram #(
    parameter int DATA_W = 1,
    parameter int DEPTH  = 2,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/voxel_material_map.sv
// channel   | ports                    | moves
// ----------+--------------------------+-------------------------------------
// request   | s_valid s_ready s_data   | fill or query request (vmm_in_t)
// result    | m_valid m_ready m_data   | one result per request (vmm_out_t)
// config    | cfg_wr_en cfg_addr       | register write, no wait, no read-back
//           | cfg_wdata                |
//
// one request at a time: a fill steps the sequencer through accept, write and
// hand-off, a query through accept, subtract, multiply, cell test, index add,
// memory read, result and hand-off; the query length is set by the multiply
// and the registered read of the occupancy memory
// the result register lets the next request in while a result still waits
// reset is synchronous, active low, and takes effect at once: the occupancy
// memory gets no clearing pass, since fills only append, a cell at or past
// the write pointer reads as empty
module voxel_material_map
    import vmm_pkg::*;
#(
    parameter int SIZE_X       = vmm_pkg::DEF_SIZE_X,
    parameter int SIZE_Y       = vmm_pkg::DEF_SIZE_Y,
    parameter int SIZE_Z       = vmm_pkg::DEF_SIZE_Z,
    parameter int NUM_ELEMENTS = vmm_pkg::DEF_NUM_ELEMENTS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  vmm_pkg::vmm_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output vmm_pkg::vmm_out_t                   m_data,
    input  logic                                cfg_wr_en,
    input  logic [vmm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [vmm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    // geometry
    localparam int CELLS    = SIZE_X * SIZE_Y * SIZE_Z;
    localparam int NYZ      = SIZE_Y * SIZE_Z;
    localparam int IDX_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int WP_W     = $clog2(CELLS + 1);
    localparam int MAX_SIZE = (SIZE_X > SIZE_Y) ?
                              ((SIZE_X > SIZE_Z) ? SIZE_X : SIZE_Z) :
                              ((SIZE_Y > SIZE_Z) ? SIZE_Y : SIZE_Z);
    localparam int CELL_W   = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int LOC_W    = DIFF_W + PITCH_W + 1;
    localparam int FRAC_W   = 32;
    localparam int INT_W    = LOC_W - FRAC_W;

    // only the low element bits count
    localparam int ELEM_USED = (NUM_ELEMENTS < ELEM_W) ? NUM_ELEMENTS : ELEM_W;
    localparam logic [ELEM_W-1:0] ELEM_KEEP = ELEM_W'((1 << ELEM_USED) - 1);

    localparam logic [INT_W-1:0] AXIS_LIMIT [3] = '{
        INT_W'(SIZE_X), INT_W'(SIZE_Y), INT_W'(SIZE_Z)
    };

    // control state
    vmm_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic [WP_W-1:0]   wp_reg, wp_next;
    logic [WP_W-1:0]   occ_reg, occ_next;
    logic [ELEM_W-1:0] seen_reg, seen_next;

    // configuration
    logic signed [COORD_W-1:0] min_reg [3];
    logic signed [COORD_W-1:0] min_next [3];
    logic [PITCH_W-1:0]        pitch_reg [3];
    logic [PITCH_W-1:0]        pitch_next [3];

    // datapath
    vmm_in_t                   req_reg, req_next;
    logic signed [DIFF_W-1:0]  diff_reg [3];
    logic signed [DIFF_W-1:0]  diff_next [3];
    logic signed [LOC_W-1:0]   loc_reg [3];
    logic signed [LOC_W-1:0]   loc_next [3];
    logic                      inside_reg, inside_next;
    logic [IDX_W-1:0]          prodx_reg, prodx_next;
    logic [IDX_W-1:0]          prody_reg, prody_next;
    logic [CELL_W-1:0]         zc_reg, zc_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    vmm_out_t                  res_reg, res_next;
    vmm_out_t                  out_reg, out_next;

    // occupancy memory port signals
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    logic             mem_wr_data;
    logic             mem_rd_en;
    logic             mem_rd_data;

    // per-axis cell test
    logic              axis_in [3];
    logic [CELL_W-1:0] axis_cell [3];

    // fill helpers
    logic [ELEM_W-1:0] fill_mask;
    logic              fill_mat;
    logic              map_full;

    vmm_ram #(
        .DATA_W (1),
        .DEPTH  (CELLS)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (idx_reg),
        .rd_data (mem_rd_data)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign fill_mask = req_reg.element_mask & ELEM_KEEP;
    assign fill_mat  = req_reg.calculated && (fill_mask != '0);
    assign map_full  = (wp_reg == WP_W'(CELLS));

    // voxel coordinate: strictly inside (0, size), floor of the product
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            axis_in[a]   = !loc_reg[a][LOC_W-1] && (loc_reg[a] != '0) &&
                           (loc_reg[a][LOC_W-1:FRAC_W] < AXIS_LIMIT[a]);
            axis_cell[a] = loc_reg[a][FRAC_W +: CELL_W];
        end
    end

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        wp_next        = wp_reg;
        occ_next       = occ_reg;
        seen_next      = seen_reg;
        min_next       = min_reg;
        pitch_next     = pitch_reg;
        req_next       = req_reg;
        diff_next      = diff_reg;
        loc_next       = loc_reg;
        inside_next    = inside_reg;
        prodx_next     = prodx_reg;
        prody_next     = prody_reg;
        zc_next        = zc_reg;
        idx_next       = idx_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = wp_reg[IDX_W-1:0];
        mem_wr_data    = fill_mat;
        mem_rd_en      = 1'b0;

        // register writes
        if (cfg_wr_en) begin
            case (vmm_cfg_idx_t'(cfg_addr))
                CFG_MIN_X:   min_next[0]   = signed'(cfg_wdata[COORD_W-1:0]);
                CFG_MIN_Y:   min_next[1]   = signed'(cfg_wdata[COORD_W-1:0]);
                CFG_MIN_Z:   min_next[2]   = signed'(cfg_wdata[COORD_W-1:0]);
                CFG_PITCH_X: pitch_next[0] = cfg_wdata[PITCH_W-1:0];
                CFG_PITCH_Y: pitch_next[1] = cfg_wdata[PITCH_W-1:0];
                CFG_PITCH_Z: pitch_next[2] = cfg_wdata[PITCH_W-1:0];
                default: ;
            endcase
        end

        // result register drains on its own handshake
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next = s_data;
                    if (vmm_op_t'(s_data.opcode) == OP_FILL) begin
                        state_next = ST_FILL;
                    end else begin
                        state_next = ST_DIFF;
                    end
                end
            end

            // append one cell at the write pointer, or flag overflow when the map is full
            ST_FILL: begin
                res_next.inside_res = 1'b0;
                if (map_full) begin
                    res_next.voxel_index  = '0;
                    res_next.has_material = 1'b0;
                    res_next.overflow     = 1'b1;
                end else begin
                    mem_wr_en             = 1'b1;
                    wp_next               = wp_reg + WP_W'(1);
                    res_next.voxel_index  = VOX_IDX_W'(wp_reg);
                    res_next.has_material = fill_mat;
                    res_next.overflow     = 1'b0;
                    if (fill_mat) begin
                        occ_next  = occ_reg + WP_W'(1);
                        seen_next = seen_reg | fill_mask;
                    end
                end
                res_next.element_union  = seen_next;
                res_next.occupied_count = OCC_W'(occ_next);
                state_next = ST_DONE;
            end

            ST_DIFF: begin
                diff_next[0] = DIFF_W'(req_reg.coord_x) - DIFF_W'(min_reg[0]);
                diff_next[1] = DIFF_W'(req_reg.coord_y) - DIFF_W'(min_reg[1]);
                diff_next[2] = DIFF_W'(req_reg.coord_z) - DIFF_W'(min_reg[2]);
                state_next   = ST_MUL;
            end

            // exact product, 32 fraction bits
            ST_MUL: begin
                for (int a = 0; a < 3; a++) begin
                    loc_next[a] = diff_reg[a] * signed'({1'b0, pitch_reg[a]});
                end
                state_next = ST_CELL;
            end

            ST_CELL: begin
                inside_next = axis_in[0] && axis_in[1] && axis_in[2];
                prodx_next  = IDX_W'(axis_cell[0]) * IDX_W'(NYZ);
                prody_next  = IDX_W'(axis_cell[1]) * IDX_W'(SIZE_Z);
                zc_next     = axis_cell[2];
                state_next  = ST_ADDR;
            end

            ST_ADDR: begin
                idx_next   = prodx_reg + prody_reg + IDX_W'(zc_reg);
                state_next = ST_READ;
            end

            // memory data arrives at the next edge
            ST_READ: begin
                mem_rd_en  = inside_reg;
                state_next = ST_RESULT_WAIT;
            end

            ST_RESULT_WAIT: begin
                res_next.inside_res     = inside_reg;
                res_next.voxel_index    = inside_reg ? VOX_IDX_W'(idx_reg) : '0;
                // cells past the write pointer were never filled
                res_next.has_material   = inside_reg && mem_rd_data &&
                                          (WP_W'(idx_reg) < wp_reg);
                res_next.overflow       = 1'b0;
                res_next.element_union  = seen_reg;
                res_next.occupied_count = OCC_W'(occ_reg);
                state_next = ST_DONE;
            end

            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            wp_reg        <= '0;
            occ_reg       <= '0;
            seen_reg      <= '0;
            for (int a = 0; a < 3; a++) begin
                min_reg[a]   <= MIN_RESET;
                pitch_reg[a] <= PITCH_RESET;
            end
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            wp_reg        <= wp_next;
            occ_reg       <= occ_next;
            seen_reg      <= seen_next;
            min_reg       <= min_next;
            pitch_reg     <= pitch_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        diff_reg   <= diff_next;
        loc_reg    <= loc_next;
        inside_reg <= inside_next;
        prodx_reg  <= prodx_next;
        prody_reg  <= prody_next;
        zc_reg     <= zc_next;
        idx_reg    <= idx_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

endmodule

>>> tb/voxel_material_map_tb.sv
`timescale 1ns / 100ps

module voxel_material_map_tb;
    import vmm_pkg::*;

    localparam int SIZE_X    = DEF_SIZE_X;
    localparam int SIZE_Y    = DEF_SIZE_Y;
    localparam int SIZE_Z    = DEF_SIZE_Z;
    localparam int MAP_CELLS = SIZE_X * SIZE_Y * SIZE_Z;
    localparam int ONE       = 65536;    // 1.0 in q16.16 and in q8.16
    localparam int PHASE_REQS = 165;

    // only the low NUM_ELEMENTS bits of a mask take part
    localparam logic [ELEM_W-1:0] ELEM_KEEP = ELEM_W'((1 << DEF_NUM_ELEMENTS) - 1);

    // mirror of the map, the registers and the running totals; predicts one
    // result per accepted request and checks results in order
    class voxel_map_mirror;
        bit                   occ_map [MAP_CELLS];
        int unsigned          wr_ptr;
        int unsigned          occ_total;
        logic [ELEM_W-1:0]    elem_seen;
        logic [COORD_W-1:0]   box_min [3];
        logic [PITCH_W-1:0]   inv_pitch [3];
        int                   axis_len [3];
        vmm_out_t             due_results [$];
        int                   mismatch_count;

        function new();
            foreach (occ_map[i]) occ_map[i] = 1'b0;
            wr_ptr    = 0;
            occ_total = 0;
            elem_seen = '0;
            foreach (box_min[i]) begin
                box_min[i]   = MIN_RESET;
                inv_pitch[i] = PITCH_RESET;
            end
            axis_len = '{SIZE_X, SIZE_Y, SIZE_Z};
            mismatch_count = 0;
        endfunction

        function void set_reg(vmm_cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_MIN_X:   box_min[0]   = val;
                CFG_MIN_Y:   box_min[1]   = val;
                CFG_MIN_Z:   box_min[2]   = val;
                CFG_PITCH_X: inv_pitch[0] = val[PITCH_W-1:0];
                CFG_PITCH_Y: inv_pitch[1] = val[PITCH_W-1:0];
                CFG_PITCH_Z: inv_pitch[2] = val[PITCH_W-1:0];
                default: ;
            endcase
        endfunction

        // exact product with 32 fraction bits, strict test against (0, size)
        function bit axis_voxel(input int axis, input logic [COORD_W-1:0] coord,
                                output longint vox);
            longint diff;
            longint loc;
            longint top;
            diff = longint'($signed(coord)) - longint'($signed(box_min[axis]));
            loc  = diff * longint'(inv_pitch[axis]);
            top  = longint'(axis_len[axis]) <<< 32;
            vox  = 0;
            if (loc <= 0 || loc >= top) return 1'b0;
            vox = loc >>> 32;
            return 1'b1;
        endfunction

        function vmm_out_t predict_voxel_result(vmm_in_t req);
            vmm_out_t          r;
            logic [ELEM_W-1:0] m;
            longint            vx, vy, vz, lin;
            bit                ix, iy, iz;
            r = '0;
            if (req.opcode == OP_FILL) begin
                m = req.element_mask & ELEM_KEEP;
                if (wr_ptr >= MAP_CELLS) begin
                    // full map: nothing written, nothing counted
                    r.overflow = 1'b1;
                end else begin
                    r.voxel_index  = VOX_IDX_W'(wr_ptr);
                    r.has_material = req.calculated && (m != '0);
                    if (r.has_material) begin
                        elem_seen = elem_seen | m;
                        occ_total++;
                    end
                    occ_map[wr_ptr] = r.has_material;
                    wr_ptr++;
                end
            end else begin
                ix = axis_voxel(0, req.coord_x, vx);
                iy = axis_voxel(1, req.coord_y, vy);
                iz = axis_voxel(2, req.coord_z, vz);
                if (ix && iy && iz) begin
                    lin = vx * SIZE_Y * SIZE_Z + vy * SIZE_Z + vz;
                    r.inside_res   = 1'b1;
                    r.voxel_index  = VOX_IDX_W'(lin);
                    r.has_material = occ_map[lin];
                end
            end
            r.element_union  = elem_seen;
            r.occupied_count = OCC_W'(occ_total);
            return r;
        endfunction

        function void note_request(vmm_in_t req);
            vmm_out_t due;
            due = predict_voxel_result(req);
            due_results = {due_results, due};
        endfunction

        function void flag(string what, vmm_out_t want, vmm_out_t got);
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t %s: expected idx=%0d in=%b mat=%b ovf=%b union=%h cnt=%0d,",
                         $time, what, want.voxel_index, want.inside_res, want.has_material,
                         want.overflow, want.element_union, want.occupied_count,
                         " got idx=%0d in=%b mat=%b ovf=%b union=%h cnt=%0d",
                         got.voxel_index, got.inside_res, got.has_material,
                         got.overflow, got.element_union, got.occupied_count);
        endfunction

        function void check_result(vmm_out_t got);
            vmm_out_t want;
            if (due_results.size() == 0) begin
                flag("result with no request outstanding", '0, got);
                return;
            end
            want = due_results.pop_front();
            if (got.voxel_index !== want.voxel_index ||
                got.inside_res !== want.inside_res ||
                got.has_material !== want.has_material ||
                got.overflow !== want.overflow ||
                got.element_union !== want.element_union ||
                got.occupied_count !== want.occupied_count)
                flag("result mismatch", want, got);
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    vmm_in_t                 s_data;
    logic                    m_valid;
    logic                    m_ready;
    vmm_out_t                m_data;
    logic                    cfg_wr_en;
    logic [CFG_ADDR_W-1:0]   cfg_addr;
    logic [CFG_DATA_W-1:0]   cfg_wdata;

    voxel_map_mirror mirror;

    // idle odds in percent per cycle, sender and receiver
    int src_idle = 38;
    int dst_idle = 53;

    voxel_material_map u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop in case a handshake never completes
    initial begin
        #60_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // result side: check what was taken at this edge, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            mirror.check_result(m_data);
        m_ready <= ($urandom_range(99) >= dst_idle);
    end

    // query request at a given point, unused fill fields random
    function automatic vmm_in_t point_at(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                         logic [COORD_W-1:0] z);
        vmm_in_t r;
        r.opcode       = OP_QUERY;
        r.element_mask = ELEM_W'($urandom);
        r.calculated   = 1'($urandom);
        r.coord_x      = x;
        r.coord_y      = y;
        r.coord_z      = z;
        return r;
    endfunction

    // fill request, unused coordinates random
    function automatic vmm_in_t fill_with(logic [ELEM_W-1:0] mask, logic calc);
        vmm_in_t r;
        r.opcode       = OP_FILL;
        r.element_mask = mask;
        r.calculated   = calc;
        r.coord_x      = $urandom;
        r.coord_y      = $urandom;
        r.coord_z      = $urandom;
        return r;
    endfunction

    function automatic vmm_in_t random_fill();
        logic [ELEM_W-1:0] mask;
        mask = ($urandom_range(7) == 0) ? '0 : ELEM_W'($urandom);
        return fill_with(mask, $urandom_range(3) != 0);
    endfunction

    // coordinate that lands in voxel vox of an axis, frac places it inside
    function automatic logic [COORD_W-1:0] aimed_coord(int axis, int vox, int unsigned frac);
        longint target;
        longint pitch;
        pitch = longint'(mirror.inv_pitch[axis]);
        if (pitch == 0) return $urandom;
        target = (longint'(vox) <<< 32) + longint'(frac);
        return COORD_W'(longint'($signed(mirror.box_min[axis])) + target / pitch);
    endfunction

    // mostly points near the write pointer, some anywhere in the box,
    // some on the edges and some plain noise
    function automatic vmm_in_t random_query();
        vmm_in_t     r;
        int unsigned pick;
        int unsigned lin;
        int          vox [3];
        int unsigned frac [3];
        r = point_at($urandom, $urandom, $urandom);
        pick = $urandom_range(99);
        if (pick < 5) return r;
        for (int a = 0; a < 3; a++) frac[a] = $urandom;
        if (pick < 65) begin
            lin = (mirror.wr_ptr > 200 ? mirror.wr_ptr - 200 : 0) + $urandom_range(219);
            lin = lin % MAP_CELLS;
            vox = '{lin / (SIZE_Y * SIZE_Z), (lin / SIZE_Z) % SIZE_Y, lin % SIZE_Z};
        end else if (pick < 90) begin
            for (int a = 0; a < 3; a++) vox[a] = $urandom_range(mirror.axis_len[a] - 1);
        end else begin
            // on the low edge, on the high edge or just inside
            for (int a = 0; a < 3; a++) begin
                case ($urandom_range(2))
                    0: vox[a] = 0;
                    1: vox[a] = mirror.axis_len[a];
                    default: vox[a] = $urandom_range(mirror.axis_len[a] - 1);
                endcase
                if ($urandom_range(1)) frac[a] = 0;
            end
        end
        r.coord_x = aimed_coord(0, vox[0], frac[0]);
        r.coord_y = aimed_coord(1, vox[1], frac[1]);
        r.coord_z = aimed_coord(2, vox[2], frac[2]);
        return r;
    endfunction

    // one request; valid stays high across back-to-back requests and only
    // drops when the sender decides to idle
    task automatic send_request(input vmm_in_t req);
        if ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        mirror.note_request(req);
    endtask

    // stop sending until every predicted result has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (mirror.due_results.size() != 0);
    endtask

    // write all six box registers, one per cycle
    task automatic load_box(input logic [COORD_W-1:0] mx, input logic [COORD_W-1:0] my,
                            input logic [COORD_W-1:0] mz, input logic [PITCH_W-1:0] px,
                            input logic [PITCH_W-1:0] py, input logic [PITCH_W-1:0] pz);
        logic [CFG_DATA_W-1:0] vals [6];
        vals = '{mx, my, mz, CFG_DATA_W'(px), CFG_DATA_W'(py), CFG_DATA_W'(pz)};
        for (int i = CFG_MIN_X; i <= CFG_PITCH_Z; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= vmm_cfg_idx_t'(i);
            cfg_wdata <= vals[i];
            @(posedge aclk);
            mirror.set_reg(vmm_cfg_idx_t'(i), vals[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        mirror    = new();
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- directed part, reset geometry: unit pitch, box at the origin
        load_box('0, '0, '0, PITCH_RESET, PITCH_RESET, PITCH_RESET);

        // query before any fill reads an empty voxel
        send_request(point_at(ONE + ONE / 2, ONE + ONE / 2, ONE + ONE / 2));
        // point on the low edge, then on the high edge
        send_request(point_at('0, ONE, ONE));
        send_request(point_at(64 * ONE, ONE, ONE));
        // just below the high edge and smallest positive step
        send_request(point_at(64 * ONE - 1, 63 * ONE + ONE / 2, ONE / 2));
        send_request(point_at(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
        // coordinate extremes
        send_request(point_at(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001));
        send_request(point_at(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));

        // fills: no element, not calculated, all elements, single elements, a mixed mask
        send_request(fill_with('0, 1'b1));
        send_request(fill_with('1, 1'b0));
        send_request(fill_with('1, 1'b1));
        send_request(fill_with(9'h001, 1'b1));
        send_request(fill_with(9'h100, 1'b1));
        send_request(fill_with(9'h0AA, 1'b1));

        // read back the cells just written along z, and one past them
        for (int k = 0; k < 7; k++)
            send_request(point_at(ONE / 2, ONE / 2, k * ONE + ONE / 2));

        // zero pitch on x puts every point outside
        wait_drained();
        load_box('0, '0, '0, '0, PITCH_RESET, PITCH_RESET);
        send_request(point_at(ONE / 2, ONE / 2, ONE / 2));
        send_request(point_at(32'h7FFF_FFFF, ONE / 2, ONE / 2));

        // ---- random part: six geometries, three idle profiles
        for (int p = 0; p < 6; p++) begin
            wait_drained();
            case (p / 2)
                0: begin src_idle = 38; dst_idle = 53; end
                1: begin src_idle = 53; dst_idle = 38; end
                default: begin src_idle = 0; dst_idle = 0; end
            endcase
            case (p)
                0: load_box('0, '0, '0, PITCH_RESET, PITCH_RESET, PITCH_RESET);
                // lowest box edge, finest pitch
                1: load_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            '1, '1, '1);
                2: load_box(32'($urandom_range(200 * ONE)) - 32'(100 * ONE),
                            32'($urandom_range(200 * ONE)) - 32'(100 * ONE),
                            32'($urandom_range(200 * ONE)) - 32'(100 * ONE),
                            PITCH_W'($urandom_range(4 * ONE, ONE / 4)),
                            PITCH_W'($urandom_range(4 * ONE, ONE / 4)),
                            PITCH_W'($urandom_range(4 * ONE, ONE / 4)));
                // highest edge on x, coarsest nonzero pitch
                3: load_box(32'h7FFF_FFFF, '0, 32'h8000_0000, 24'd1, PITCH_RESET, '1);
                4: load_box($urandom, $urandom, $urandom,
                            PITCH_W'($urandom_range(24'hFF_FFFF, 1)),
                            PITCH_W'($urandom_range(24'hFF_FFFF, 1)),
                            PITCH_W'($urandom_range(24'hFF_FFFF, 1)));
                default: load_box(-32'(10 * ONE), 32'(5 * ONE), '0,
                                  PITCH_W'(2 * ONE), PITCH_W'(ONE / 2),
                                  PITCH_W'(3 * ONE / 2));
            endcase
            for (int i = 0; i < PHASE_REQS; i++) begin
                // sender holds off once per phase until the block is empty
                if (i == PHASE_REQS / 2) wait_drained();
                send_request(($urandom_range(99) < 35) ? random_fill() : random_query());
            end
        end

        // ---- a last few fills and queries on the reset geometry
        wait_drained();
        load_box('0, '0, '0, PITCH_RESET, PITCH_RESET, PITCH_RESET);
        send_request(fill_with('1, 1'b1));
        send_request(fill_with('1, 1'b1));
        send_request(random_fill());
        send_request(random_fill());
        for (int i = 0; i < 40; i++)
            send_request(random_query());

        // let any stray result show up as unexpected before the verdict
        wait_drained();
        repeat (20) @(posedge aclk);
        if (mirror.mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
